[rtl/assert_macros.svh]
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bptc_pkg.sv]
package bptc_pkg;

    localparam int RAW_W      = 24;
    localparam int CAL_W      = 16;
    localparam int NUM_CAL    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_W     = 19;
    localparam int PRES_W     = 32;

    localparam int DT_W       = 25;
    localparam int XPROD_W    = 42;
    localparam int DD_W       = 50;
    localparam int TDIFF_W    = 19;
    localparam int OFFD_W     = 36;
    localparam int SENSD_W    = 35;
    localparam int T2_W       = 18;
    localparam int OFF_W      = 37;
    localparam int SENS_W     = 36;
    localparam int SQ_W       = 35;
    localparam int OFF2_W     = 37;
    localparam int SENS2_W    = 36;
    localparam int OFFF_W     = 39;
    localparam int SENSF_W    = 38;
    localparam int PP_SPLIT   = 18;
    localparam int PP_LO_W    = RAW_W + PP_SPLIT;
    localparam int PP_HI_W    = RAW_W + 1 + SENSF_W - PP_SPLIT;
    localparam int PROD_W     = 63;
    localparam int Q1_W       = PROD_W - 21;
    localparam int Q2_W       = Q1_W + 1;
    localparam int PRES_RAW_W = Q2_W - 15;

    localparam int TEMP_REF     = 2000;
    localparam int OFF2_GAIN    = 61;
    localparam int TEMP_SHIFT   = 23;
    localparam int C2_SHIFT     = 17;
    localparam int C1_SHIFT     = 16;
    localparam int OFF_SHIFT    = 6;
    localparam int SENS_SHIFT   = 7;
    localparam int T2_SHIFT     = 31;
    localparam int OFF2_SHIFT   = 4;
    localparam int PROD_SHIFT   = 21;
    localparam int PRES_SHIFT   = 15;
    localparam int C5_SHIFT     = 8;

    localparam int NUM_STAGES = 11;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS   = 3'd0,
        REG_OFF    = 3'd1,
        REG_TCS    = 3'd2,
        REG_TCO    = 3'd3,
        REG_TREF   = 3'd4,
        REG_TSLOPE = 3'd5
    } cal_idx_t;

    typedef struct packed {
        logic ld_pp;
        logic ld_sum;
    } mul_ld_t;

endpackage

[rtl/bptc_wide_mul.sv]
module bptc_wide_mul
    import bptc_pkg::*;
(
    input  logic                       clk,
    input  mul_ld_t                    ld,
    input  logic [RAW_W-1:0]           a,
    input  logic signed [SENSF_W-1:0]  b,
    output logic signed [PROD_W-1:0]   p
);

    logic [PP_LO_W-1:0]        pp_lo_reg;
    logic signed [PP_HI_W-1:0] pp_hi_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [PP_LO_W-1:0]        pp_lo_next;
    logic signed [PP_HI_W-1:0] pp_hi_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [SENSF_W-PP_SPLIT-1:0] b_hi;

    assign b_hi       = b[SENSF_W-1:PP_SPLIT];
    assign pp_lo_next = {{PP_SPLIT{1'b0}}, a} * {{RAW_W{1'b0}}, b[PP_SPLIT-1:0]};
    assign pp_hi_next = $signed({1'b0, a}) * b_hi;
    assign prod_next  = ($signed({{(PROD_W-PP_HI_W){pp_hi_reg[PP_HI_W-1]}}, pp_hi_reg})
                         <<< PP_SPLIT)
                        + $signed({{(PROD_W-PP_LO_W){1'b0}}, pp_lo_reg});

    always_ff @(posedge clk)
    begin
        if (ld.ld_pp)
        begin
            pp_lo_reg <= pp_lo_next;
            pp_hi_reg <= pp_hi_next;
        end
        if (ld.ld_sum)
        begin
            prod_reg <= prod_next;
        end
    end

    assign p = prod_reg;

endmodule

[rtl/baro_pressure_temp_compensation.sv]
// Barometric compensation pipeline: takes one raw pressure and temperature conversion pair
// per beat and returns the compensated temperature (0.01 degC), the pressure (0.01 mbar) and
// a flag for the second-order low-temperature correction. It accepts one pair every cycle
// unless in_stall is high, and splits the pressure product into two partial products over
// two register stages. Empty stages close up while the output is stalled. The user must
// write calibration words through the cfg port while idle; the block does not enforce it.
`include "assert_macros.svh"

module baro_pressure_temp_compensation
    import bptc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CAL_W-1:0]          cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [RAW_W-1:0]          raw_pressure,
    input  logic [RAW_W-1:0]          raw_temperature,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [TEMP_W-1:0]  temperature_centi,
    output logic signed [PRES_W-1:0]  pressure_centi_mbar,
    output logic                      low_temp_applied
);

    localparam logic [XPROD_W-1:0] TEMP_BIAS = (XPROD_W'(1) << TEMP_SHIFT) - XPROD_W'(1);
    localparam logic [XPROD_W-1:0] OFF_BIAS  = (XPROD_W'(1) << OFF_SHIFT) - XPROD_W'(1);
    localparam logic [XPROD_W-1:0] SENS_BIAS = (XPROD_W'(1) << SENS_SHIFT) - XPROD_W'(1);
    localparam logic [PROD_W-1:0]  PROD_BIAS = (PROD_W'(1) << PROD_SHIFT) - PROD_W'(1);
    localparam logic [Q2_W-1:0]    PRES_BIAS = (Q2_W'(1) << PRES_SHIFT) - Q2_W'(1);
    localparam logic signed [TEMP_W-1:0] TEMP_REF_S = TEMP_W'(TEMP_REF);

    localparam int ST_DT   = 1;
    localparam int ST_MUL  = 2;
    localparam int ST_DIV  = 3;
    localparam int ST_BASE = 4;
    localparam int ST_CORR = 5;
    localparam int ST_APPL = 6;
    localparam int ST_PP   = 7;
    localparam int ST_SUM  = 8;
    localparam int ST_Q1   = 9;
    localparam int ST_Q2   = 10;
    localparam int ST_OUT  = 11;

    logic [CAL_W-1:0] cal_reg [NUM_CAL];

    logic [NUM_STAGES:1]   vld_reg;
    logic [NUM_STAGES+1:1] rdy;
    logic [NUM_STAGES:1]   ld;
    logic [NUM_STAGES:0]   vin;

    // stage 1
    logic [RAW_W-1:0]         s1_d1_reg;
    logic signed [DT_W-1:0]   s1_dt_reg;
    logic signed [DT_W-1:0]   s1_dt_next;
    // stage 2
    logic [RAW_W-1:0]           s2_d1_reg;
    logic signed [XPROD_W-1:0]  s2_tprod_reg, s2_oprod_reg, s2_sprod_reg;
    logic signed [DD_W-1:0]     s2_dd_reg;
    // stage 3
    logic [RAW_W-1:0]           s3_d1_reg;
    logic signed [TDIFF_W-1:0]  s3_tdiff_reg;
    logic signed [OFFD_W-1:0]   s3_offd_reg;
    logic signed [SENSD_W-1:0]  s3_sensd_reg;
    logic [T2_W-1:0]            s3_t2_reg;
    logic [XPROD_W-1:0]         tsum, osum, ssum;
    // stage 4
    logic [RAW_W-1:0]           s4_d1_reg;
    logic signed [TEMP_W-1:0]   s4_temp_reg;
    logic signed [OFF_W-1:0]    s4_off_reg;
    logic signed [SENS_W-1:0]   s4_sens_reg;
    logic [SQ_W-1:0]            s4_sq_reg;
    logic [T2_W-1:0]            s4_t2_reg;
    logic                       s4_low_reg;
    logic signed [2*TDIFF_W-1:0] sq_full;
    // stage 5
    logic [RAW_W-1:0]           s5_d1_reg;
    logic signed [TEMP_W-1:0]   s5_temp_reg;
    logic signed [OFF_W-1:0]    s5_off_reg;
    logic signed [SENS_W-1:0]   s5_sens_reg;
    logic [OFF2_W-1:0]          s5_off2_reg;
    logic [SENS2_W-1:0]         s5_sens2_reg;
    logic [T2_W-1:0]            s5_t2_reg;
    logic                       s5_low_reg;
    logic [OFF2_W+OFF2_SHIFT-1:0] off2_full;
    // stage 6
    logic [RAW_W-1:0]           s6_d1_reg;
    logic signed [TEMP_W-1:0]   s6_temp_reg;
    logic signed [OFFF_W-1:0]   s6_off_reg;
    logic signed [SENSF_W-1:0]  s6_sens_reg;
    logic                       s6_low_reg;
    // stages 7 to 11
    logic signed [TEMP_W-1:0]   s7_temp_reg, s8_temp_reg, s9_temp_reg, s10_temp_reg;
    logic signed [TEMP_W-1:0]   s11_temp_reg;
    logic                       s7_low_reg, s8_low_reg, s9_low_reg, s10_low_reg, s11_low_reg;
    logic signed [OFFF_W-1:0]   s7_off_reg, s8_off_reg, s9_off_reg;
    logic signed [PROD_W-1:0]   s8_prod;
    logic [PROD_W-1:0]          psum;
    logic signed [Q1_W-1:0]     s9_q1_reg;
    logic signed [Q2_W-1:0]     s10_q2_reg;
    logic [Q2_W-1:0]            qsum;
    logic signed [PRES_W-1:0]   s11_pres_reg;
    mul_ld_t                    mul_ld;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CAL; i++)
            begin
                cal_reg[i] <= '0;
            end
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_SENS:   cal_reg[REG_SENS]   <= cfg_data;
                REG_OFF:    cal_reg[REG_OFF]    <= cfg_data;
                REG_TCS:    cal_reg[REG_TCS]    <= cfg_data;
                REG_TCO:    cal_reg[REG_TCO]    <= cfg_data;
                REG_TREF:   cal_reg[REG_TREF]   <= cfg_data;
                REG_TSLOPE: cal_reg[REG_TSLOPE] <= cfg_data;
                default:    ;
            endcase
        end
    end

    // close up bubbles: a stage moves when it is empty or the one after it moves
    always_comb
    begin
        rdy[NUM_STAGES+1] = !out_stall;
        for (int i = NUM_STAGES; i >= 1; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign vin = {vld_reg, in_valid};

    always_comb
    begin
        for (int i = 1; i <= NUM_STAGES; i++)
        begin
            ld[i] = rdy[i] && vin[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= NUM_STAGES; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vin[i-1];
                end
            end
        end
    end

    assign in_stall = !rdy[1];
    assign out_valid = vld_reg[NUM_STAGES];

    assign s1_dt_next = $signed({1'b0, raw_temperature})
                        - $signed({1'b0, cal_reg[REG_TREF], {C5_SHIFT{1'b0}}});

    assign tsum = $unsigned(s2_tprod_reg) + (s2_tprod_reg[XPROD_W-1] ? TEMP_BIAS : '0);
    assign osum = $unsigned(s2_oprod_reg) + (s2_oprod_reg[XPROD_W-1] ? OFF_BIAS : '0);
    assign ssum = $unsigned(s2_sprod_reg) + (s2_sprod_reg[XPROD_W-1] ? SENS_BIAS : '0);

    assign sq_full   = s3_tdiff_reg * s3_tdiff_reg;
    assign off2_full = (OFF2_W+OFF2_SHIFT)'(s4_sq_reg) * (OFF2_W+OFF2_SHIFT)'(OFF2_GAIN);

    assign mul_ld.ld_pp  = ld[ST_PP];
    assign mul_ld.ld_sum = ld[ST_SUM];

    bptc_wide_mul u_mul
    (
        .clk (clk),
        .ld  (mul_ld),
        .a   (s6_d1_reg),
        .b   (s6_sens_reg),
        .p   (s8_prod)
    );

    assign psum = $unsigned(s8_prod) + (s8_prod[PROD_W-1] ? PROD_BIAS : '0);
    assign qsum = $unsigned(s10_q2_reg) + (s10_q2_reg[Q2_W-1] ? PRES_BIAS : '0);

    always_ff @(posedge clk)
    begin
        if (ld[ST_DT])
        begin
            s1_d1_reg <= raw_pressure;
            s1_dt_reg <= s1_dt_next;
        end
        if (ld[ST_MUL])
        begin
            s2_d1_reg    <= s1_d1_reg;
            s2_tprod_reg <= s1_dt_reg * $signed({1'b0, cal_reg[REG_TSLOPE]});
            s2_oprod_reg <= s1_dt_reg * $signed({1'b0, cal_reg[REG_TCO]});
            s2_sprod_reg <= s1_dt_reg * $signed({1'b0, cal_reg[REG_TCS]});
            s2_dd_reg    <= s1_dt_reg * s1_dt_reg;
        end
        if (ld[ST_DIV])
        begin
            s3_d1_reg    <= s2_d1_reg;
            s3_tdiff_reg <= $signed(tsum[XPROD_W-1:TEMP_SHIFT]);
            s3_offd_reg  <= $signed(osum[XPROD_W-1:OFF_SHIFT]);
            s3_sensd_reg <= $signed(ssum[XPROD_W-1:SENS_SHIFT]);
            s3_t2_reg    <= s2_dd_reg[T2_SHIFT+T2_W-1:T2_SHIFT];
        end
        if (ld[ST_BASE])
        begin
            s4_d1_reg   <= s3_d1_reg;
            s4_temp_reg <= TEMP_REF_S + s3_tdiff_reg;
            s4_off_reg  <= $signed({{(OFF_W-CAL_W-C2_SHIFT){1'b0}}, cal_reg[REG_OFF],
                                    {C2_SHIFT{1'b0}}})
                           + $signed({s3_offd_reg[OFFD_W-1], s3_offd_reg});
            s4_sens_reg <= $signed({{(SENS_W-CAL_W-C1_SHIFT){1'b0}}, cal_reg[REG_SENS],
                                    {C1_SHIFT{1'b0}}})
                           + $signed({s3_sensd_reg[SENSD_W-1], s3_sensd_reg});
            s4_sq_reg   <= sq_full[SQ_W-1:0];
            s4_t2_reg   <= s3_t2_reg;
            s4_low_reg  <= s3_tdiff_reg[TDIFF_W-1];
        end
        if (ld[ST_CORR])
        begin
            s5_d1_reg    <= s4_d1_reg;
            s5_temp_reg  <= s4_temp_reg;
            s5_off_reg   <= s4_off_reg;
            s5_sens_reg  <= s4_sens_reg;
            s5_off2_reg  <= off2_full[OFF2_W+OFF2_SHIFT-1:OFF2_SHIFT];
            s5_sens2_reg <= {s4_sq_reg, 1'b0};
            s5_t2_reg    <= s4_t2_reg;
            s5_low_reg   <= s4_low_reg;
        end
        if (ld[ST_APPL])
        begin
            s6_d1_reg   <= s5_d1_reg;
            s6_low_reg  <= s5_low_reg;
            s6_temp_reg <= s5_temp_reg
                           - (s5_low_reg ? $signed({1'b0, s5_t2_reg}) : TEMP_W'(0));
            s6_off_reg  <= $signed({{(OFFF_W-OFF_W){s5_off_reg[OFF_W-1]}}, s5_off_reg})
                           - $signed(s5_low_reg ? {{(OFFF_W-OFF2_W){1'b0}}, s5_off2_reg}
                                                : OFFF_W'(0));
            s6_sens_reg <= $signed({{(SENSF_W-SENS_W){s5_sens_reg[SENS_W-1]}}, s5_sens_reg})
                           - $signed(s5_low_reg ? {{(SENSF_W-SENS2_W){1'b0}}, s5_sens2_reg}
                                                : SENSF_W'(0));
        end
        if (ld[ST_PP])
        begin
            s7_temp_reg <= s6_temp_reg;
            s7_low_reg  <= s6_low_reg;
            s7_off_reg  <= s6_off_reg;
        end
        if (ld[ST_SUM])
        begin
            s8_temp_reg <= s7_temp_reg;
            s8_low_reg  <= s7_low_reg;
            s8_off_reg  <= s7_off_reg;
        end
        if (ld[ST_Q1])
        begin
            s9_temp_reg <= s8_temp_reg;
            s9_low_reg  <= s8_low_reg;
            s9_off_reg  <= s8_off_reg;
            s9_q1_reg   <= $signed(psum[PROD_W-1:PROD_SHIFT]);
        end
        if (ld[ST_Q2])
        begin
            s10_temp_reg <= s9_temp_reg;
            s10_low_reg  <= s9_low_reg;
            s10_q2_reg   <= $signed({s9_q1_reg[Q1_W-1], s9_q1_reg})
                            - $signed({{(Q2_W-OFFF_W){s9_off_reg[OFFF_W-1]}}, s9_off_reg});
        end
        if (ld[ST_OUT])
        begin
            s11_temp_reg <= s10_temp_reg;
            s11_low_reg  <= s10_low_reg;
            s11_pres_reg <= $signed({{(PRES_W-PRES_RAW_W){qsum[Q2_W-1]}},
                                     qsum[Q2_W-1:PRES_SHIFT]});
        end
    end

    assign temperature_centi   = s11_temp_reg;
    assign pressure_centi_mbar = s11_pres_reg;
    assign low_temp_applied    = s11_low_reg;

    `ASSERT_IMPLIES(a_low_flag_below_ref, clk, rst_n, out_valid && low_temp_applied, temperature_centi < TEMP_REF_S, "low-temperature flag with temperature at or above reference")
    `ASSERT_IMPLIES(a_no_flag_at_ref, clk, rst_n, out_valid && !low_temp_applied, temperature_centi >= TEMP_REF_S, "temperature below reference without correction flag")
    `ASSERT_IMPLIES(a_empty_out_never_stalls, clk, rst_n, !out_valid, !in_stall, "input stalled while output stage is empty")
    `ASSERT_NEXT(a_accept_fills_first, clk, rst_n, in_valid && !in_stall, vld_reg[ST_DT], "accepted beat missing from first stage")

endmodule

[bench/baro_comp_checker.sv]
`timescale 1ns / 1ps

module baro_comp_checker
    import bptc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [CAL_W-1:0]         cfg_data,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [RAW_W-1:0]         raw_pressure,
    input  logic [RAW_W-1:0]         raw_temperature,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [TEMP_W-1:0] temperature_centi,
    input  logic signed [PRES_W-1:0] pressure_centi_mbar,
    input  logic                     low_temp_applied,
    output int                       outstanding,
    output int                       results_checked,
    output int                       cold_results,
    output int                       mismatches
);

    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_centi;
        logic signed [PRES_W-1:0] pres_centi;
        logic                     cold;
    } comp_out_t;

    localparam longint PRES_MAX = 64'sd2147483647;
    localparam longint PRES_MIN = -64'sd2147483648;

    logic [CAL_W-1:0] cal_word [NUM_CAL];
    comp_out_t        expected_q [$];

    // divide by 2^k, truncating toward zero
    function automatic longint shr_trunc(input longint x, input int k);
        return x / (longint'(1) << k);
    endfunction

    function automatic comp_out_t compensate(input logic [RAW_W-1:0] d1_raw,
                                             input logic [RAW_W-1:0] d2_raw);
        longint    d1;
        longint    d2;
        longint    c1;
        longint    c2;
        longint    c3;
        longint    c4;
        longint    c5;
        longint    c6;
        longint    dt;
        longint    temp;
        longint    off;
        longint    sens;
        longint    dtemp;
        longint    sq;
        longint    pres;
        comp_out_t r;
        d1 = longint'(d1_raw);
        d2 = longint'(d2_raw);
        c1 = longint'(cal_word[REG_SENS]);
        c2 = longint'(cal_word[REG_OFF]);
        c3 = longint'(cal_word[REG_TCS]);
        c4 = longint'(cal_word[REG_TCO]);
        c5 = longint'(cal_word[REG_TREF]);
        c6 = longint'(cal_word[REG_TSLOPE]);
        r.cold = 1'b0;

        dt   = d2 - (c5 << C5_SHIFT);
        temp = TEMP_REF + shr_trunc(dt * c6, TEMP_SHIFT);
        off  = (c2 << C2_SHIFT) + shr_trunc(c4 * dt, OFF_SHIFT);
        sens = (c1 << C1_SHIFT) + shr_trunc(c3 * dt, SENS_SHIFT);

        if (temp < TEMP_REF)
        begin
            dtemp  = temp - TEMP_REF;
            sq     = dtemp * dtemp;
            temp   = temp - shr_trunc(dt * dt, T2_SHIFT);
            off    = off - shr_trunc(OFF2_GAIN * sq, OFF2_SHIFT);
            sens   = sens - 2 * sq;
            r.cold = 1'b1;
        end

        pres = shr_trunc(shr_trunc(d1 * sens, PROD_SHIFT) - off, PRES_SHIFT);
        if (pres > PRES_MAX)
            pres = PRES_MAX;
        if (pres < PRES_MIN)
            pres = PRES_MIN;

        r.temp_centi = temp[TEMP_W-1:0];
        r.pres_centi = pres[PRES_W-1:0];
        return r;
    endfunction

    task automatic report_fault(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        comp_out_t want;
        if (!rst_n)
        begin
            foreach (cal_word[i])
                cal_word[i] = '0;
            expected_q.delete();
            outstanding     <= 0;
            results_checked = 0;
            cold_results    = 0;
            mismatches      = 0;
        end
        else
        begin
            if (cfg_wr_en && cfg_index < NUM_CAL)
                cal_word[cfg_index] = cfg_data;

            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report_fault($sformatf("result beat with nothing expected: temp %0d pres %0d",
                                           temperature_centi, pressure_centi_mbar));
                else
                begin
                    want = expected_q.pop_front();
                    results_checked = results_checked + 1;
                    if (want.cold)
                        cold_results = cold_results + 1;
                    if (temperature_centi !== want.temp_centi)
                        report_fault($sformatf("temperature_centi got %0d want %0d",
                                               temperature_centi, want.temp_centi));
                    if (pressure_centi_mbar !== want.pres_centi)
                        report_fault($sformatf("pressure_centi_mbar got %0d want %0d",
                                               pressure_centi_mbar, want.pres_centi));
                    if (low_temp_applied !== want.cold)
                        report_fault($sformatf("low_temp_applied got %b want %b",
                                               low_temp_applied, want.cold));
                end
            end

            if (in_valid && !in_stall)
                expected_q.push_back(compensate(raw_pressure, raw_temperature));

            outstanding <= expected_q.size();
        end
    end

endmodule

[bench/tb_baro_pressure_temp_compensation.sv]
`timescale 1ns / 1ps

module tb_baro_pressure_temp_compensation
    import bptc_pkg::*;
();

    localparam int               LONG_HOLD     = 150;
    localparam int               IDLE_LIMIT    = 3000;
    localparam int               RANDOM_PHASES = 9;
    localparam int               PHASE_PAIRS   = 200;
    localparam int               SETTLE_CYCLES = 30;
    localparam logic [RAW_W-1:0] RAW_MAX       = '1;
    localparam logic [RAW_W-1:0] D1_TYPICAL    = RAW_W'(6465444);
    localparam logic [RAW_W-1:0] D2_TYPICAL    = RAW_W'(8077636);

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_wr_en;
    logic [CFG_IDX_W-1:0]     cfg_index;
    logic [CAL_W-1:0]         cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    logic [RAW_W-1:0]         raw_pressure;
    logic [RAW_W-1:0]         raw_temperature;
    logic                     out_valid;
    logic                     out_stall;
    logic signed [TEMP_W-1:0] temperature_centi;
    logic signed [PRES_W-1:0] pressure_centi_mbar;
    logic                     low_temp_applied;

    int outstanding;
    int results_checked;
    int cold_results;
    int mismatches;

    bit quiet        = 1'b0;
    int holds_asked  = 0;
    int idle_cycles  = 0;
    int pairs_sent   = 0;
    int settings_run = 0;
    int send_calm    = 0;

    baro_pressure_temp_compensation dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .raw_pressure        (raw_pressure),
        .raw_temperature     (raw_temperature),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar),
        .low_temp_applied    (low_temp_applied)
    );

    baro_comp_checker chk (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .raw_pressure        (raw_pressure),
        .raw_temperature     (raw_temperature),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .temperature_centi   (temperature_centi),
        .pressure_centi_mbar (pressure_centi_mbar),
        .low_temp_applied    (low_temp_applied),
        .outstanding         (outstanding),
        .results_checked     (results_checked),
        .cold_results        (cold_results),
        .mismatches          (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en)
                idle_cycles <= 0;
            else if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Watchdog: no beat for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stall bursts, calm stretches and requested long holds
    initial
    begin
        int stall_left;
        int calm_left;
        int holds_done;
        stall_left = 0;
        calm_left  = 0;
        holds_done = 0;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_done != holds_asked)
            begin
                holds_done = holds_done + 1;
                stall_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                out_stall <= 1'b1;
            end
            else if (quiet || calm_left > 0)
            begin
                if (calm_left > 0)
                    calm_left = calm_left - 1;
                out_stall <= 1'b0;
            end
            else if ($urandom_range(0, 3) == 0)
            begin
                stall_left = $urandom_range(0, 16);
                out_stall <= 1'b1;
            end
            else
            begin
                calm_left = $urandom_range(5, 60);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_pair(input logic [RAW_W-1:0] p, input logic [RAW_W-1:0] t);
        raw_pressure    <= p;
        raw_temperature <= t;
        in_valid        <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pairs_sent = pairs_sent + 1;
        if (quiet || send_calm > 0)
        begin
            if (send_calm > 0)
                send_calm = send_calm - 1;
        end
        else if ($urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        else
            send_calm = $urandom_range(5, 60);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic program_cal(input logic [CAL_W-1:0] w [NUM_CAL]);
        for (int i = 0; i < NUM_CAL; i++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_index <= cal_idx_t'(i);
            cfg_data  <= w[i];
            @(posedge clk);
        end
        // indexes past the last word: must be dropped
        for (int i = NUM_CAL; i < 2 ** CFG_IDX_W; i++)
        begin
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= CAL_W'($urandom);
            @(posedge clk);
        end
        cfg_wr_en    <= 1'b0;
        settings_run = settings_run + 1;
    endtask

    initial
    begin
        logic [CAL_W-1:0] cal [NUM_CAL];
        logic [RAW_W-1:0] tref;
        logic [RAW_W-1:0] p;
        logic [RAW_W-1:0] t;
        rst_n           = 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        raw_pressure    <= '0;
        raw_temperature <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // calibration still at reset: all words zero
        send_pair(RAW_MAX, RAW_MAX);
        send_pair('0, '0);
        send_pair(RAW_MAX, '0);
        drain();

        cal = '{16'd46372, 16'd43981, 16'd29059, 16'd27842, 16'd31553, 16'd28165};
        program_cal(cal);
        tref = RAW_W'(cal[REG_TREF]) << C5_SHIFT;
        send_pair(D1_TYPICAL, D2_TYPICAL);
        send_pair(D1_TYPICAL, tref);
        send_pair(D1_TYPICAL, tref + RAW_W'(1));
        send_pair(D1_TYPICAL, tref - RAW_W'(1));
        send_pair(D1_TYPICAL, tref - RAW_W'(297));
        send_pair(D1_TYPICAL, tref - RAW_W'(298));
        send_pair(D1_TYPICAL, tref - RAW_W'(1500000));
        send_pair(D1_TYPICAL, '0);
        send_pair(D1_TYPICAL, RAW_MAX);
        send_pair('0, D2_TYPICAL);
        send_pair(RAW_MAX, D2_TYPICAL);
        drain();

        foreach (cal[i])
            cal[i] = '1;
        program_cal(cal);
        send_pair(RAW_MAX, RAW_MAX);
        send_pair(RAW_MAX, '0);
        send_pair('0, '0);
        send_pair('0, RAW_MAX);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            foreach (cal[i])
            begin
                case ($urandom_range(0, 5))
                    0:       cal[i] = '0;
                    1:       cal[i] = '1;
                    default: cal[i] = CAL_W'($urandom);
                endcase
            end
            if (ph == RANDOM_PHASES - 1)
                quiet <= 1'b1;
            program_cal(cal);
            if (ph == 2 || ph == 5)
                holds_asked <= holds_asked + 1;
            tref = RAW_W'(cal[REG_TREF]) << C5_SHIFT;
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                p = RAW_W'($urandom);
                case ($urandom_range(0, 7))
                    0:       t = tref + RAW_W'($urandom_range(0, 1200)) - RAW_W'(600);
                    1:       t = $urandom_range(0, 1) ? RAW_MAX : '0;
                    default: t = RAW_W'($urandom);
                endcase
                if ($urandom_range(0, 15) == 0)
                    p = $urandom_range(0, 1) ? RAW_MAX : '0;
                send_pair(p, t);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Sent %0d conversion pairs under %0d calibration settings, %0d long output holds",
                 pairs_sent, settings_run, holds_asked);
        $display("Compared %0d results, %0d of them with the low-temperature correction",
                 results_checked, cold_results);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bptc_pkg.sv
rtl/bptc_wide_mul.sv
rtl/baro_pressure_temp_compensation.sv
bench/baro_comp_checker.sv
bench/tb_baro_pressure_temp_compensation.sv
